/* src/vdle_pkg.sv */
// Shared types, constants and helper functions of the vector display list engine.
// Depends on nothing; every other file of the block imports it.
package vdle_pkg;

  // Return stack depth and fraction bits of the beam position.
  localparam int STACK_DEPTH = 4;
  localparam int FRAC_BITS   = 18;

  // Beam register width and width of the signed screen and clip arithmetic.
  localparam int BW  = 48;
  localparam int CW  = 40;
  localparam int MW  = 2 * CW;
  localparam int SCW = $clog2(STACK_DEPTH + 1);
  localparam int SIW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // Request opcodes.
  localparam logic OP_START = 1'b0;
  localparam logic OP_EXEC  = 1'b1;

  // Instruction opcodes (high nibble of byte1).
  localparam logic [3:0] OPC_LONG_MAX = 4'h9;
  localparam logic [3:0] OPC_LOAD     = 4'hA;
  localparam logic [3:0] OPC_HALT     = 4'hB;
  localparam logic [3:0] OPC_CALL     = 4'hC;
  localparam logic [3:0] OPC_RET      = 4'hD;
  localparam logic [3:0] OPC_JUMP     = 4'hE;
  localparam logic [3:0] OPC_SHORT    = 4'hF;

  // Result status codes.
  localparam logic [1:0] ST_CONT = 2'd0;
  localparam logic [1:0] ST_HALT = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;
  localparam logic [1:0] ST_OVF  = 2'd3;

  // Screen clip window.
  localparam logic signed [CW-1:0] CLIP_LO = CW'(-32768);
  localparam logic signed [CW-1:0] CLIP_HI = CW'(32767);

  // Offset and rounding terms of the screen mapping.
  localparam logic signed [BW+7:0] SCR_OFS = {{(BW+7){1'b0}}, 1'b1} << (15 + FRAC_BITS);
  localparam logic signed [BW+7:0] SCR_RND = ({{(BW+7){1'b0}}, 1'b1} << FRAC_BITS) - 1;

  typedef struct packed {
    logic       op;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
  } in_t;

  typedef struct packed {
    logic               vector_valid;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic [15:0]        next_pc;
    logic [1:0]         status;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       exec;
    logic       scr;
    logic       md_start;
    logic       clip_wr;
    logic       finish;
    logic       emit;
    logic [2:0] phase;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic draw_go;
    logic need;
    logic reject;
    logic md_done;
  } sts_t;

  // Maps a Q30.18 position to a screen coordinate, truncating toward zero.
  function automatic logic signed [CW-1:0] screen(input logic [BW-1:0] pos);
    logic signed [BW+7:0] s;
    s = ($signed({{8{pos[BW-1]}}, pos}) <<< 6) - SCR_OFS;
    if (s < 0) begin
      s = s + SCR_RND;
    end
    s = s >>> FRAC_BITS;
    return s[CW-1:0];
  endfunction

endpackage

/* src/vector_display_list_engine.sv */
// Top level of the vector display list engine: controller plus datapath.
// Depends on vdle_pkg, vdle_ctrl and vdle_datapath.

// One request runs one display-list instruction and gives exactly one result. Non-drawing
// instructions, start-frame requests and draws with zero intensity pass from execute straight
// to the result hand-off. A drawing instruction with nonzero intensity also runs the screen
// mapping and eight clip checks, and waits on the interpolation unit for every clip step that
// cuts the line; up to eight steps can cut, so the worst case is set by the bit-serial multiply
// and restoring divide of the interpolation unit. A new request is taken once the previous one
// has been handed to the result register, while that result still waits for out_ready.
module vector_display_list_engine
  import vdle_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  cmd_t cmd;
  sts_t sts;

  vdle_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  vdle_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

/* src/vdle_muldiv.sv */
// Iterative a*b/c unit: shift-add multiply, then restoring division, truncating toward zero.
// Depends on vdle_pkg.
module vdle_muldiv
  import vdle_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [CW-1:0] a,
  input  logic signed [CW-1:0] b,
  input  logic signed [CW-1:0] c,
  output logic                 done,
  output logic signed [CW-1:0] q
);

  localparam int NW = $clog2(MW);

  logic            busy;
  logic            dividing;
  logic [NW-1:0]   cnt;
  logic            neg;
  logic [MW-1:0]   mcand;
  logic [CW-1:0]   mplier;
  logic [MW-1:0]   prod;
  logic [CW-1:0]   uc;
  logic [CW:0]     rem;
  logic [CW-1:0]   quo;
  logic [CW:0]     rem_shift;
  logic            fits;

  // One division step: bring in the next product bit and try a subtract.
  assign rem_shift = {rem[CW-1:0], prod[MW-1]};
  assign fits      = rem_shift >= {1'b0, uc};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      dividing <= 1'b0;
      done     <= 1'b0;
      cnt      <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        dividing <= 1'b0;
        cnt      <= '0;
      end else if (busy) begin
        if (!dividing) begin
          if (cnt == NW'(CW - 1)) begin
            dividing <= 1'b1;
            cnt      <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end else begin
          if (cnt == NW'(MW - 1)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
      end
    end
  end

  // Operand magnitudes and the product and quotient shift registers.
  always_ff @(posedge clk) begin
    if (start) begin
      neg    <= (a[CW-1] ^ b[CW-1]) ^ c[CW-1];
      mcand  <= {{CW{1'b0}}, (a[CW-1] ? -a : a)};
      mplier <= b[CW-1] ? -b : b;
      uc     <= c[CW-1] ? -c : c;
      prod   <= '0;
      rem    <= '0;
      quo    <= '0;
    end else if (busy && !dividing) begin
      if (mplier[0]) begin
        prod <= prod + mcand;
      end
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end else if (busy) begin
      prod <= prod << 1;
      rem  <= fits ? (rem_shift - {1'b0, uc}) : rem_shift;
      quo  <= {quo[CW-2:0], fits};
    end
  end

  assign q = (uc == '0) ? '0 : (neg ? -$signed(quo) : $signed(quo));

endmodule

/* src/vdle_datapath.sv */
// Datapath: program counter, return stack, beam registers, clip endpoints and result register.
// Depends on vdle_pkg and vdle_muldiv.
module vdle_datapath
  import vdle_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  in_t  in_data,
  input  cmd_t cmd,
  output sts_t sts,
  output out_t out_data
);

  in_t                 inreg;
  logic [15:0]         pc;
  logic [15:0]         stack [STACK_DEPTH];
  logic [SCW-1:0]      cnt;
  logic                halted;
  logic [3:0]          gs;
  logic [BW-1:0]       beam_x;
  logic [BW-1:0]       beam_y;
  logic signed [CW-1:0] sx, sy, ex, ey;
  logic [1:0]          res_status;

  logic [3:0]          opc;
  logic [10:0]         wx, wy;
  logic [15:0]         target;
  logic                is_long, is_short;
  logic [3:0]          intensity;
  logic [6:0]          e_amt;
  logic [6:0]          up, down;
  logic                dx_s, dy_s;
  logic [9:0]          dx_m, dy_m;

  logic                pass1, axis_y, hi;
  logic signed [CW-1:0] bnd, fa, fo, ma, mo;
  logic signed [CW-1:0] md_q;
  logic                md_done;

  // Sign-magnitude delta shifted left by the exponent, in 48-bit two's complement.
  function automatic logic [BW-1:0] shifted(input logic s, input logic [9:0] m,
                                            input logic [6:0] sh);
    logic [BW-1:0] v;
    v = {{(BW-10){1'b0}}, m} << sh;
    return s ? -v : v;
  endfunction

  // Instruction field decode.
  assign opc       = inreg.byte1[7:4];
  assign wx        = {inreg.byte3[2:0], inreg.byte2};
  assign wy        = {inreg.byte1[2:0], inreg.byte0};
  assign target    = {3'd0, inreg.byte1[3:0], inreg.byte0, 1'b0};
  assign is_long   = opc <= OPC_LONG_MAX;
  assign is_short  = opc == OPC_SHORT;
  assign intensity = is_long ? inreg.byte3[7:4] : inreg.byte0[7:4];

  // Delta exponent from the opcode, the short-vector scale bits and the global scale.
  always_comb begin
    if (is_long) begin
      up   = 7'd0;
      down = 7'(OPC_LONG_MAX - opc);
      dx_s = wx[10];
      dx_m = wx[9:0];
      dy_s = wy[10];
      dy_m = wy[9:0];
    end else begin
      up   = 7'd1 + {6'd0, inreg.byte1[3]} + {5'd0, inreg.byte0[3], 1'b0};
      down = 7'd0;
      dx_s = inreg.byte0[2];
      dx_m = {8'd0, inreg.byte0[1:0]};
      dy_s = inreg.byte1[2];
      dy_m = {8'd0, inreg.byte1[1:0]};
    end
    if (gs[3]) begin
      e_amt = 7'(FRAC_BITS) + up - down - (7'd16 - {3'd0, gs});
    end else begin
      e_amt = 7'(FRAC_BITS) + up - down + {3'd0, gs};
    end
  end

  // Clip step decode: low x, low y, high x, high y, first toward the end, then the start.
  always_comb begin
    pass1  = cmd.phase[2];
    axis_y = cmd.phase[0];
    hi     = cmd.phase[1];
    bnd    = hi ? CLIP_HI : CLIP_LO;
    if (!pass1) begin
      fa = axis_y ? sy : sx;
      fo = axis_y ? sx : sy;
      ma = axis_y ? ey : ex;
      mo = axis_y ? ex : ey;
    end else begin
      fa = axis_y ? ey : ex;
      fo = axis_y ? ex : ey;
      ma = axis_y ? sy : sx;
      mo = axis_y ? sx : sy;
    end
  end

  assign sts.draw_go = (inreg.op == OP_EXEC) && !halted && (is_long || is_short) &&
                       (intensity != 4'd0);
  assign sts.need    = hi ? (ma > bnd) : (ma < bnd);
  assign sts.reject  = sts.need && (hi ? (fa > bnd) : (fa < bnd));
  assign sts.md_done = md_done;

  vdle_muldiv u_md (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.md_start),
    .a     (mo - fo),
    .b     (bnd - fa),
    .c     (ma - fa),
    .done  (md_done),
    .q     (md_q)
  );

  // Control state of the engine.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc     <= '0;
      cnt    <= '0;
      halted <= 1'b1;
      gs     <= '0;
      beam_x <= '0;
      beam_y <= '0;
    end else if (cmd.exec) begin
      if (inreg.op == OP_START) begin
        pc     <= '0;
        cnt    <= '0;
        gs     <= '0;
        halted <= 1'b0;
      end else if (!halted) begin
        if (is_long || is_short) begin
          beam_x <= beam_x + shifted(dx_s, dx_m, e_amt);
          beam_y <= beam_y + shifted(dy_s, dy_m, e_amt);
          pc     <= pc + (is_long ? 16'd4 : 16'd2);
        end else begin
          case (opc)
            OPC_LOAD: begin
              beam_x <= shifted(wx[10], wx[9:0], 7'(FRAC_BITS));
              beam_y <= shifted(wy[10], wy[9:0], 7'(FRAC_BITS));
              gs     <= inreg.byte3[7:4];
              pc     <= pc + 16'd4;
            end
            OPC_HALT: begin
              halted <= 1'b1;
            end
            OPC_CALL: begin
              if (cnt >= SCW'(STACK_DEPTH)) begin
                halted <= 1'b1;
              end else begin
                cnt <= cnt + 1'b1;
                pc  <= target;
              end
            end
            OPC_RET: begin
              if (cnt != '0) begin
                cnt <= cnt - 1'b1;
                pc  <= stack[SIW'(cnt - 1'b1)];
              end
            end
            OPC_JUMP: begin
              pc <= target;
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  // Payload registers: input latch, stack entries, status, endpoints and result.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      inreg <= in_data;
    end
    if (cmd.exec) begin
      if (inreg.op == OP_START) begin
        res_status <= ST_CONT;
      end else if (halted) begin
        res_status <= ST_HALT;
      end else begin
        case (opc)
          OPC_HALT: res_status <= ST_HALT;
          OPC_CALL: begin
            if (cnt >= SCW'(STACK_DEPTH)) begin
              res_status <= ST_OVF;
            end else begin
              stack[SIW'(cnt)] <= pc + 16'd2;
              res_status       <= (target == '0) ? ST_DONE : ST_CONT;
            end
          end
          OPC_RET:  res_status <= (cnt == '0) ? ST_DONE : ST_CONT;
          OPC_JUMP: res_status <= (target == '0) ? ST_DONE : ST_CONT;
          default:  res_status <= ST_CONT;
        endcase
      end
      sx <= screen(beam_x);
      sy <= screen(beam_y);
    end
    if (cmd.scr) begin
      ex <= screen(beam_x);
      ey <= screen(beam_y);
    end
    if (cmd.clip_wr) begin
      case ({pass1, axis_y})
        2'b00: begin ex <= bnd; ey <= fo + md_q; end
        2'b01: begin ey <= bnd; ex <= fo + md_q; end
        2'b10: begin sx <= bnd; sy <= fo + md_q; end
        default: begin sy <= bnd; sx <= fo + md_q; end
      endcase
    end
    if (cmd.finish) begin
      out_data.vector_valid <= cmd.emit;
      out_data.start_x      <= cmd.emit ? sx[15:0] : 16'd0;
      out_data.start_y      <= cmd.emit ? sy[15:0] : 16'd0;
      out_data.end_x        <= cmd.emit ? ex[15:0] : 16'd0;
      out_data.end_y        <= cmd.emit ? ey[15:0] : 16'd0;
      out_data.next_pc      <= pc;
      out_data.status       <= res_status;
    end
  end

endmodule

/* src/vdle_ctrl.sv */
// Controller: sequences execute, screen mapping, the eight clip steps and result hand-off.
// Depends on vdle_pkg.
module vdle_ctrl
  import vdle_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_SCR   = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0] state, state_next;
  logic [2:0] phase, phase_next;
  logic       emit, emit_next;
  logic       fin_go;

  assign in_ready = state == S_IDLE;
  assign fin_go   = (state == S_FIN) && (!out_valid || out_ready);

  // Next state and commands.
  always_comb begin
    state_next   = state;
    phase_next   = phase;
    emit_next    = emit;
    cmd          = '0;
    cmd.phase    = phase;
    cmd.emit     = emit;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        emit_next  = 1'b0;
        state_next = sts.draw_go ? S_SCR : S_FIN;
      end
      S_SCR: begin
        cmd.scr    = 1'b1;
        phase_next = 3'd0;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (sts.reject) begin
          state_next = S_FIN;
        end else if (sts.need) begin
          cmd.md_start = 1'b1;
          state_next   = S_WAIT;
        end else if (phase == 3'd7) begin
          emit_next  = 1'b1;
          state_next = S_FIN;
        end else begin
          phase_next = phase + 1'b1;
        end
      end
      S_WAIT: begin
        if (sts.md_done) begin
          cmd.clip_wr = 1'b1;
          if (phase == 3'd7) begin
            emit_next  = 1'b1;
            state_next = S_FIN;
          end else begin
            phase_next = phase + 1'b1;
            state_next = S_CHECK;
          end
        end
      end
      S_FIN: begin
        if (fin_go) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= '0;
      emit      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      emit  <= emit_next;
      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* src/vdle_checker.sv */
// Port-level checker of the vector display list engine, bound to the top level.
// Depends on vdle_pkg.
module vdle_checker
  import vdle_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // A result without a vector carries zero endpoints.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.vector_valid |->
      out_data.start_x == 16'sd0 && out_data.start_y == 16'sd0 &&
      out_data.end_x == 16'sd0 && out_data.end_y == 16'sd0)
    else $error("endpoints nonzero without a vector");

  // Only a continuing draw produces a vector.
  a_stat: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.vector_valid |-> out_data.status == ST_CONT)
    else $error("vector with a halting status");

  // The block works on one request at a time.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

endmodule

bind vector_display_list_engine vdle_checker u_chk (.*);

/* sim/vdle_scoreboard.sv */
`timescale 1ns / 1ps
// Request and result checker for the vector display list engine testbench.
// Depends on vdle_pkg; predicts every result and compares it with the block's output.
module vdle_scoreboard
  import vdle_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_ready,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  out_t out_data,
  output int   fail_count,
  output int   pending
);

  localparam logic [BW-1:0] POS_MASK = {BW{1'b1}};

  // Model copy of the engine state.
  logic [15:0]    pc_m;
  logic [15:0]    stack_m [STACK_DEPTH];
  int             depth_m;
  logic           halted_m;
  logic [3:0]     scale_m;
  logic [BW-1:0]  beam_x_m;
  logic [BW-1:0]  beam_y_m;

  out_t expected_q [$];

  assign pending = expected_q.size();

  // Sign-magnitude field to integer.
  function automatic longint sm_value(input int raw, input int sign_bit);
    longint m;
    m = raw & (sign_bit - 1);
    return (raw & sign_bit) ? -m : m;
  endfunction

  // Delta scaled by 2^e as a 48-bit two's complement step.
  function automatic logic [BW-1:0] beam_step(input longint d, input int e);
    longint unsigned m;
    m = (d < 0) ? -d : d;
    m = m << e;
    return (d < 0) ? BW'(-m) : BW'(m);
  endfunction

  // Q30.18 position to screen coordinate, truncated toward zero.
  function automatic longint to_screen(input logic [BW-1:0] pos);
    logic signed [BW-1:0] sp;
    longint s;
    sp = pos;
    s = longint'(sp) * 64 - (longint'(32768) << FRAC_BITS);
    return s / (longint'(1) << FRAC_BITS);
  endfunction

  // a*b/c with an exact product, truncated toward zero.
  function automatic longint interp(input longint a, input longint b, input longint c);
    logic signed [127:0] pa, pb, pc, q, m;
    logic neg;
    pa = a;
    pb = b;
    pc = c;
    if (c == 0 || (pc < 0 ? -pc : pc) > 128'h3FFF_FFFF_FFFF_FFFF) return 0;
    q = (pa * pb) / pc;
    neg = q < 0;
    m = neg ? -q : q;
    m = m & 128'h3FFF_FFFF_FFFF_FFFF;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  // Clips the far end of a line to the screen window; 0 when clipped away.
  function automatic bit clip_far(input longint sx, input longint sy,
                                  inout longint ex, inout longint ey);
    if (ex < -32768) begin
      if (sx < -32768) return 0;
      ey = sy + interp(ey - sy, -32768 - sx, ex - sx);
      ex = -32768;
    end
    if (ey < -32768) begin
      if (sy < -32768) return 0;
      ex = sx + interp(ex - sx, -32768 - sy, ey - sy);
      ey = -32768;
    end
    if (ex > 32767) begin
      if (sx > 32767) return 0;
      ey = sy + interp(ey - sy, 32767 - sx, ex - sx);
      ex = 32767;
    end
    if (ey > 32767) begin
      if (sy > 32767) return 0;
      ex = sx + interp(ex - sx, 32767 - sy, ey - sy);
      ey = 32767;
    end
    return 1;
  endfunction

  // Moves the beam and fills in the vector if it stays visible.
  function automatic void move_beam(input longint dx, input longint dy, input int up,
                                    input int down, input int bright, inout out_t r);
    int e;
    longint sx, sy, ex, ey;
    e = FRAC_BITS + up - down;
    if (scale_m >= 8) e = e - (16 - scale_m);
    else e = e + scale_m;
    sx = to_screen(beam_x_m);
    sy = to_screen(beam_y_m);
    beam_x_m = (beam_x_m + beam_step(dx, e)) & POS_MASK;
    beam_y_m = (beam_y_m + beam_step(dy, e)) & POS_MASK;
    ex = to_screen(beam_x_m);
    ey = to_screen(beam_y_m);
    if (!clip_far(sx, sy, ex, ey)) return;
    if (!clip_far(ex, ey, sx, sy)) return;
    if (bright == 0) return;
    r.vector_valid = 1'b1;
    r.start_x = sx[15:0];
    r.start_y = sy[15:0];
    r.end_x = ex[15:0];
    r.end_y = ey[15:0];
  endfunction

  // Runs one request against the model state and returns its result.
  function automatic out_t run_instruction(input in_t q);
    out_t r;
    logic [3:0] opc;
    int wx, wy;
    logic [15:0] target;
    int s;
    r = '0;
    r.status = ST_CONT;
    opc = q.byte1[7:4];
    wx = int'({q.byte3, q.byte2} & 16'h07FF);
    wy = int'({q.byte1, q.byte0} & 16'h07FF);
    target = {3'd0, q.byte1[3:0], q.byte0, 1'b0};
    if (q.op == OP_START) begin
      pc_m = '0;
      depth_m = 0;
      scale_m = '0;
      halted_m = 1'b0;
    end else if (halted_m) begin
      r.status = ST_HALT;
    end else if (opc <= OPC_LONG_MAX) begin
      move_beam(sm_value(wx, 'h400), sm_value(wy, 'h400), 0, 9 - int'(opc),
                int'(q.byte3[7:4]), r);
      pc_m = pc_m + 16'd4;
    end else if (opc == OPC_LOAD) begin
      beam_x_m = beam_step(sm_value(wx, 'h400), FRAC_BITS);
      beam_y_m = beam_step(sm_value(wy, 'h400), FRAC_BITS);
      scale_m = q.byte3[7:4];
      pc_m = pc_m + 16'd4;
    end else if (opc == OPC_HALT) begin
      halted_m = 1'b1;
      r.status = ST_HALT;
    end else if (opc == OPC_CALL) begin
      if (depth_m >= STACK_DEPTH) begin
        halted_m = 1'b1;
        r.status = ST_OVF;
      end else begin
        stack_m[depth_m] = pc_m + 16'd2;
        depth_m++;
        pc_m = target;
        r.status = (target == 0) ? ST_DONE : ST_CONT;
      end
    end else if (opc == OPC_RET) begin
      if (depth_m == 0) begin
        r.status = ST_DONE;
      end else begin
        depth_m--;
        pc_m = stack_m[depth_m];
      end
    end else if (opc == OPC_JUMP) begin
      pc_m = target;
      r.status = (target == 0) ? ST_DONE : ST_CONT;
    end else begin
      s = 1 + int'(q.byte1[3]) + 2 * int'(q.byte0[3]);
      move_beam(sm_value(int'(q.byte0[2:0]), 4), sm_value(int'(q.byte1[2:0]), 4), s, 0,
                int'(q.byte0[7:4]), r);
      pc_m = pc_m + 16'd2;
    end
    r.next_pc = pc_m;
    return r;
  endfunction

  // Predict on every accepted request, compare on every accepted result.
  always @(posedge clk) begin
    out_t want;
    bit bad;
    if (rst) begin
      pc_m = '0;
      depth_m = 0;
      halted_m = 1'b1;
      scale_m = '0;
      beam_x_m = '0;
      beam_y_m = '0;
      fail_count = 0;
      expected_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          fail_count = fail_count + 1;
          if (fail_count <= 10) $display("unexpected result %p", out_data);
        end else begin
          want = expected_q.pop_front();
          bad = want.vector_valid != out_data.vector_valid ||
                want.start_x != out_data.start_x || want.start_y != out_data.start_y ||
                want.end_x != out_data.end_x || want.end_y != out_data.end_y ||
                want.next_pc != out_data.next_pc || want.status != out_data.status;
          if (bad) begin
            fail_count = fail_count + 1;
            if (fail_count <= 10) begin
              $display("result mismatch: expected %p got %p", want, out_data);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_q.insert(expected_q.size(), run_instruction(in_data));
      end
    end
  end

endmodule

/* sim/tb_vector_display_list_engine.sv */
`timescale 1ns / 1ps
// Testbench top for the vector display list engine: clock, reset, requests and verdict.
// Depends on vdle_pkg, vector_display_list_engine and vdle_scoreboard.
module tb_vector_display_list_engine;
  import vdle_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  out_t out_data;
  int   fail_count;
  int   pending;

  int   tx_idle = 35;
  int   rx_idle = 52;
  bit   rx_hold = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  vector_display_list_engine DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  vdle_scoreboard checker_i (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  // Receiver readiness, with an optional long hold-off.
  always @(posedge clk) begin
    out_ready <= !rx_hold && ($urandom_range(99) >= rx_idle);
  end

  // Builds one request.
  function automatic in_t mk(input logic op, input logic [7:0] b0, input logic [7:0] b1,
                             input logic [7:0] b2, input logic [7:0] b3);
    in_t r;
    r.op = op;
    r.byte0 = b0;
    r.byte1 = b1;
    r.byte2 = b2;
    r.byte3 = b3;
    return r;
  endfunction

  // Offers one request until accepted, then maybe idles.
  task automatic send(input in_t q);
    int gap;
    in_valid <= 1'b1;
    in_data <= q;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      gap = $urandom_range(4, 1);
      repeat (gap) @(posedge clk);
    end
  endtask

  // Random request: mostly instructions of a running list, some frame restarts.
  function automatic in_t random_request();
    in_t r;
    r = mk(OP_EXEC, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    if ($urandom_range(99) < 6) r.op = OP_START;
    // Keep the global scale of most loads small so that many vectors stay visible.
    if (r.byte1[7:4] == OPC_LOAD && $urandom_range(3) != 0) begin
      r.byte3[7:4] = 4'($urandom_range(2));
    end
    return r;
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: frame start, extremes of moves, every kind of instruction, stack limits.
    send(mk(OP_EXEC, 8'h00, 8'h10, 8'h00, 8'hF0));
    send(mk(OP_START, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send(mk(OP_EXEC, 8'hFF, {OPC_LOAD, 4'h3}, 8'hFF, 8'h03));
    send(mk(OP_EXEC, 8'hFF, 8'h07, 8'hFF, 8'hF7));
    send(mk(OP_EXEC, 8'hFF, 8'h93, 8'hFF, 8'hF3));
    send(mk(OP_EXEC, 8'h00, {OPC_LOAD, 4'h4}, 8'h00, 8'h74));
    send(mk(OP_EXEC, 8'hFF, 8'h93, 8'hFF, 8'hF3));
    send(mk(OP_EXEC, 8'h00, {OPC_LOAD, 4'h0}, 8'h00, 8'h80));
    send(mk(OP_EXEC, 8'h55, 8'h52, 8'hAA, 8'h05));
    send(mk(OP_EXEC, 8'hFF, {OPC_SHORT, 4'hF}, 8'h00, 8'h00));
    send(mk(OP_EXEC, 8'h0B, {OPC_SHORT, 4'h4}, 8'h00, 8'h00));
    send(mk(OP_EXEC, 8'h10, {OPC_CALL, 4'h1}, 8'h00, 8'h00));
    send(mk(OP_EXEC, 8'h20, {OPC_CALL, 4'h2}, 8'h00, 8'h00));
    send(mk(OP_EXEC, 8'h00, {OPC_RET, 4'h0}, 8'h00, 8'h00));
    send(mk(OP_EXEC, 8'hFF, {OPC_CALL, 4'hF}, 8'h00, 8'h00));
    send(mk(OP_EXEC, 8'h00, {OPC_CALL, 4'h0}, 8'h00, 8'h00));
    send(mk(OP_EXEC, 8'h30, {OPC_CALL, 4'h3}, 8'h00, 8'h00));
    send(mk(OP_EXEC, 8'h40, {OPC_CALL, 4'h4}, 8'h00, 8'h00));
    send(mk(OP_EXEC, 8'h00, 8'h00, 8'h00, 8'h00));
    send(mk(OP_START, 8'h00, 8'h00, 8'h00, 8'h00));
    send(mk(OP_EXEC, 8'h00, {OPC_RET, 4'h0}, 8'h00, 8'h00));
    send(mk(OP_EXEC, 8'h00, {OPC_JUMP, 4'h0}, 8'h00, 8'h00));
    send(mk(OP_EXEC, 8'hFF, {OPC_JUMP, 4'hF}, 8'h00, 8'h00));
    send(mk(OP_EXEC, 8'h00, {OPC_HALT, 4'h0}, 8'h00, 8'h00));
    send(mk(OP_EXEC, 8'h00, 8'h90, 8'h00, 8'h10));

    // Random phases: receiver-heavy idling, then sender-heavy, then none.
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle = (phase == 0) ? 35 : (phase == 1) ? 52 : 0;
      rx_idle = (phase == 0) ? 52 : (phase == 1) ? 35 : 0;
      send(mk(OP_START, 8'h00, 8'h00, 8'h00, 8'h00));
      for (int i = 0; i < 160; i++) begin
        if (phase == 1 && i == 40) begin
          fork
            begin
              rx_hold = 1;
              repeat (3000) @(posedge clk);
              rx_hold = 0;
            end
          join_none
        end
        send(random_request());
      end
      drain();
    end

    drain();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
